@@ design/rsig_pkg.sv @@
`timescale 1ns / 1ps
// Package with the shared types and constants of the repeat signature table.
package rsig_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int SIG_W             = 32;
	localparam int COUNT_W           = 16;
	localparam int LIMIT_W           = 16;
	localparam logic [COUNT_W-1:0] COUNT_TOP   = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

	typedef enum logic [1:0] {
		ACT_IGNORED  = 2'd0,
		ACT_MATCHED  = 2'd1,
		ACT_INSERTED = 2'd2,
		ACT_PURGED   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MATCH,
		ST_PURGE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [SIG_W-1:0]   key_first;
		logic [SIG_W-1:0]   key_second;
		logic [SIG_W-1:0]   key_third;
		logic [COUNT_W-1:0] seen_count;
	} entry_t;

endpackage

@@ design/rsig_ifs.sv @@
`timescale 1ns / 1ps
// Handshake interfaces for signature beats and result beats.
interface rsig_sig_if import rsig_pkg::*; ();
	logic              valid;
	logic              ready;
	logic signed [SIG_W-1:0] sig_first;
	logic signed [SIG_W-1:0] sig_second;
	logic signed [SIG_W-1:0] sig_third;

	modport source (output valid, sig_first, sig_second, sig_third, input ready);
	modport sink (input valid, sig_first, sig_second, sig_third, output ready);
endinterface

interface rsig_res_if import rsig_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    is_repeat;
	action_t action;

	modport source (output valid, is_repeat, action, input ready);
	modport sink (input valid, is_repeat, action, output ready);
endinterface

@@ design/repeat_signature_table_top.sv @@
`timescale 1ns / 1ps
// Repeat signature table: sequenced scan over an entry memory with one read and one write port.
//
// Channel  Dir  Fields                              Handshake
// sig      in   sig_first, sig_second, sig_third    valid / ready
// res      out  is_repeat, action                   valid / ready
// cfg      in   cfg_wdata (repeat limit)            cfg_we, no wait
//
// One scan unit reads one entry per cycle from the memory and compares it.
// A zero signature goes straight to the result; a match ends the scan at the matching entry,
// an insert follows a full scan, and a purge follows a full scan and a second pass.
// After reset a clearing pass writes every entry to zero before the first beat is taken.
// sig.ready is high only while idle; a result waits in the output register
// while the next signature is taken.
module repeat_signature_table_top import rsig_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	rsig_sig_if.sink           sig,
	rsig_res_if.source         res
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] N_CW    = CW'(TABLE_ENTRIES);
	localparam logic [CW-1:0] LAST_CW = CW'(TABLE_ENTRIES - 1);

	state_t             state_q, state_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [LIMIT_W-1:0] limit_q;
	logic [SIG_W-1:0]   sig1_q, sig2_q, sig3_q;
	logic               valid_s1;
	logic [AW-1:0]      addr_s1;
	logic               free_found_q, free_found_d;
	logic [AW-1:0]      free_addr_q, free_addr_d;
	logic               pend_repeat_q, pend_repeat_d;
	action_t            pend_action_q, pend_action_d;
	logic               res_valid_q;
	logic               res_repeat_q;
	action_t            res_action_q;
	logic               load_res;
	logic               scan_issue;

	entry_t             mem_q [TABLE_ENTRIES];
	entry_t             rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	logic               hit;
	logic               sig_zero;

	assign sig_zero = (sig.sig_first == '0) && (sig.sig_second == '0) && (sig.sig_third == '0);
	assign hit = valid_s1 && (rd_data_q.key_first == sig1_q) &&
		(rd_data_q.key_second == sig2_q) && (rd_data_q.key_third == sig3_q);
	assign rd_addr = (cnt_q < N_CW) ? cnt_q[AW-1:0] : '0;
	assign scan_issue = ((state_q == ST_MATCH) || (state_q == ST_PURGE)) && (cnt_q < N_CW);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		free_found_d  = free_found_q;
		free_addr_d   = free_addr_q;
		pend_repeat_d = pend_repeat_q;
		pend_action_d = pend_action_q;
		wr_en         = 1'b0;
		wr_addr       = addr_s1;
		wr_data       = '0;
		sig.ready     = 1'b0;
		load_res      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[AW-1:0];
				if (cnt_q == LAST_CW) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_IDLE: begin
				sig.ready = 1'b1;
				if (sig.valid) begin
					cnt_d        = '0;
					free_found_d = 1'b0;
					if (sig_zero) begin
						pend_repeat_d = 1'b0;
						pend_action_d = ACT_IGNORED;
						state_d       = ST_RESULT;
					end else begin
						state_d = ST_MATCH;
					end
				end
			end
			ST_MATCH: begin
				if (cnt_q != N_CW) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (hit) begin
					wr_en   = 1'b1;
					wr_addr = addr_s1;
					wr_data = rd_data_q;
					if (rd_data_q.seen_count != COUNT_TOP) begin
						wr_data.seen_count = rd_data_q.seen_count + 1'b1;
					end
					pend_repeat_d = (rd_data_q.seen_count >= limit_q);
					pend_action_d = ACT_MATCHED;
					state_d       = ST_RESULT;
				end else if (valid_s1) begin
					if ((rd_data_q.seen_count == '0) && !free_found_q) begin
						free_found_d = 1'b1;
						free_addr_d  = addr_s1;
					end
				end else if (cnt_q == N_CW) begin
					if (free_found_q) begin
						wr_en              = 1'b1;
						wr_addr            = free_addr_q;
						wr_data.key_first  = sig1_q;
						wr_data.key_second = sig2_q;
						wr_data.key_third  = sig3_q;
						wr_data.seen_count = COUNT_W'(1);
						pend_repeat_d      = 1'b0;
						pend_action_d      = ACT_INSERTED;
						state_d            = ST_RESULT;
					end else begin
						cnt_d   = '0;
						state_d = ST_PURGE;
					end
				end
			end
			ST_PURGE: begin
				if (cnt_q != N_CW) begin
					cnt_d = cnt_q + 1'b1;
				end
				if (valid_s1) begin
					if (rd_data_q.seen_count <= limit_q) begin
						wr_en   = 1'b1;
						wr_addr = addr_s1;
					end
				end else if (cnt_q == N_CW) begin
					pend_repeat_d = 1'b0;
					pend_action_d = ACT_PURGED;
					state_d       = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!res_valid_q || res.ready) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			cnt_q        <= '0;
			limit_q      <= LIMIT_RESET;
			valid_s1     <= 1'b0;
			free_found_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			valid_s1     <= scan_issue;
			free_found_q <= free_found_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1       <= rd_addr;
		free_addr_q   <= free_addr_d;
		pend_repeat_q <= pend_repeat_d;
		pend_action_q <= pend_action_d;
		if (sig.valid && sig.ready) begin
			sig1_q <= sig.sig_first;
			sig2_q <= sig.sig_second;
			sig3_q <= sig.sig_third;
		end
		if (load_res) begin
			res_repeat_q <= pend_repeat_q;
			res_action_q <= pend_action_q;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.is_repeat = res_repeat_q;
	assign res.action    = res_action_q;

endmodule

@@ design/rsig_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the repeat signature table and their binding.
module rsig_checker import rsig_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             sig_valid,
	input logic             sig_ready,
	input logic [SIG_W-1:0] sig_first,
	input logic [SIG_W-1:0] sig_second,
	input logic [SIG_W-1:0] sig_third,
	input logic             res_valid,
	input logic             res_ready,
	input logic             is_repeat,
	input action_t          action
);

	logic zero_beat;

	assign zero_beat = sig_valid && sig_ready && (sig_first == '0) &&
		(sig_second == '0) && (sig_third == '0);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(action) && $stable(is_repeat))
		else $error("Result beat changed while stalled.");

	a_repeat_only_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_repeat |-> action == ACT_MATCHED)
		else $error("Repeat flagged on a beat that is not a match.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		sig_valid && sig_ready |=> !sig_ready)
		else $error("Signature taken while the previous one is in work.");

	a_zero_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		zero_beat && !res_valid |-> ##2 (res_valid && action == ACT_IGNORED && !is_repeat))
		else $error("Zero signature did not give an ignored result.");

endmodule

bind repeat_signature_table_top rsig_checker u_rsig_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.sig_valid  (sig.valid),
	.sig_ready  (sig.ready),
	.sig_first  (sig.sig_first),
	.sig_second (sig.sig_second),
	.sig_third  (sig.sig_third),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.is_repeat  (res.is_repeat),
	.action     (res.action)
);

@@ test/repeat_signature_table_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the repeat signature table with its own table predictor.
module repeat_signature_table_top_tb;
	import rsig_pkg::*;

	localparam int ENTRIES     = TABLE_ENTRIES_DEF;
	localparam int LATENCY     = 2 * ENTRIES + 8;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [SIG_W-1:0] word_a;
		logic [SIG_W-1:0] word_b;
		logic [SIG_W-1:0] word_c;
	} sig_words_t;

	typedef struct packed {
		logic    is_repeat;
		action_t action;
	} verdict_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	rsig_sig_if sig_bus ();
	rsig_res_if res_bus ();

	repeat_signature_table_top #(.TABLE_ENTRIES(ENTRIES)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sig       (sig_bus),
		.res       (res_bus)
	);

	// Predicted table contents and repeat limit.
	logic [SIG_W-1:0]   tab_a [ENTRIES];
	logic [SIG_W-1:0]   tab_b [ENTRIES];
	logic [SIG_W-1:0]   tab_c [ENTRIES];
	logic [COUNT_W-1:0] tab_count [ENTRIES];
	logic [LIMIT_W-1:0] limit_copy;

	sig_words_t pending_sigs [$];
	sig_words_t sig_pool [$];
	verdict_t   expected_verdicts [$];

	int   idle_pct;
	int   errors;
	int   tally [4];
	int   repeats_seen;
	int   quiet_cycles;
	logic sig_beat;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic log_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		errors++;
	endtask

	task automatic track_signature(input sig_words_t s, output verdict_t v);
		v.is_repeat = 1'b0;
		v.action    = ACT_IGNORED;
		if (s == '0)
			return;
		for (int k = 0; k < ENTRIES; k++) begin
			if (tab_a[k] == s.word_a && tab_b[k] == s.word_b && tab_c[k] == s.word_c) begin
				v.action    = ACT_MATCHED;
				v.is_repeat = (tab_count[k] >= limit_copy);
				if (tab_count[k] != COUNT_TOP)
					tab_count[k] = tab_count[k] + 1'b1;
				return;
			end
		end
		for (int k = 0; k < ENTRIES; k++) begin
			if (tab_count[k] == '0) begin
				tab_a[k]     = s.word_a;
				tab_b[k]     = s.word_b;
				tab_c[k]     = s.word_c;
				tab_count[k] = COUNT_W'(1);
				v.action     = ACT_INSERTED;
				return;
			end
		end
		for (int k = 0; k < ENTRIES; k++) begin
			if (tab_count[k] <= limit_copy) begin
				tab_a[k]     = '0;
				tab_b[k]     = '0;
				tab_c[k]     = '0;
				tab_count[k] = '0;
			end
		end
		v.action = ACT_PURGED;
	endtask

	function automatic int occupied();
		int n;
		n = 0;
		for (int k = 0; k < ENTRIES; k++)
			if (tab_count[k] != '0)
				n++;
		return n;
	endfunction

	function automatic bit drained();
		return pending_sigs.size() == 0 && !sig_bus.valid && expected_verdicts.size() == 0;
	endfunction

	function automatic logic [SIG_W-1:0] odd_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_sig(input logic [SIG_W-1:0] a, b, c);
		sig_words_t s;
		s = {a, b, c};
		pending_sigs.push_back(s);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (!drained());
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		wait_drained();
		repeat (LATENCY) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// About half the signatures reuse earlier ones, often recent ones, so counts climb past the limit.
	task automatic run_random(input int count);
		sig_words_t s;
		int         made;
		int         idx;
		int         r;
		made = 0;
		while (made < count) begin
			r = $urandom_range(99);
			if (r < 5) begin
				s = '0;
			end else if (r < 55 && sig_pool.size() > 0) begin
				if ($urandom_range(1))
					idx = sig_pool.size() - 1 - $urandom_range((sig_pool.size() > 8) ? 7 :
						sig_pool.size() - 1);
				else
					idx = $urandom_range(sig_pool.size() - 1);
				s = sig_pool[idx];
			end else begin
				s = {odd_word(), odd_word(), odd_word()};
				sig_pool.push_back(s);
				if (sig_pool.size() > 96)
					void'(sig_pool.pop_front());
			end
			pending_sigs.push_back(s);
			if (s != '0)
				made++;
		end
		wait_drained();
	endtask

	always @(negedge clk) begin : driver
		sig_words_t nxt;
		if (!arst_n) begin
			sig_bus.valid <= 1'b0;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= idle_pct);
			if (!sig_bus.valid || sig_beat) begin
				if (pending_sigs.size() > 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_sigs.pop_front();
					sig_bus.sig_first  <= nxt.word_a;
					sig_bus.sig_second <= nxt.word_b;
					sig_bus.sig_third  <= nxt.word_c;
					sig_bus.valid      <= 1'b1;
				end else begin
					sig_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		verdict_t   got;
		verdict_t   want;
		sig_words_t s;
		if (!arst_n) begin
			sig_beat <= 1'b0;
		end else begin
			sig_beat <= sig_bus.valid && sig_bus.ready;
			if (cfg_we)
				limit_copy = cfg_wdata;
			if (res_bus.valid && res_bus.ready) begin
				got.is_repeat = res_bus.is_repeat;
				got.action    = res_bus.action;
				tally[got.action]++;
				if (got.is_repeat)
					repeats_seen++;
				if (expected_verdicts.size() == 0) begin
					log_mismatch("result beat with no signature outstanding");
				end else begin
					want = expected_verdicts.pop_front();
					if (got.action !== want.action)
						log_mismatch($sformatf("action %0d, expected %0d",
							got.action, want.action));
					if (got.is_repeat !== want.is_repeat)
						log_mismatch($sformatf("is_repeat %0b, expected %0b",
							got.is_repeat, want.is_repeat));
				end
			end
			if (sig_bus.valid && sig_bus.ready) begin
				s = {sig_bus.sig_first, sig_bus.sig_second, sig_bus.sig_third};
				track_signature(s, want);
				expected_verdicts.push_back(want);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((sig_bus.valid && sig_bus.ready) || (res_bus.valid && res_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no beat for %0d cycles, %0d results outstanding",
					STALL_LIMIT, expected_verdicts.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [SIG_W-1:0] tag;
		int               need;
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		sig_bus.valid      = 1'b0;
		sig_bus.sig_first  = '0;
		sig_bus.sig_second = '0;
		sig_bus.sig_third  = '0;
		res_bus.ready      = 1'b0;
		idle_pct           = 13;
		errors             = 0;
		repeats_seen       = 0;
		quiet_cycles       = 0;
		tag                = 32'h5A5A_0000;
		limit_copy         = LIMIT_RESET;
		for (int k = 0; k < 4; k++)
			tally[k] = 0;
		for (int k = 0; k < ENTRIES; k++) begin
			tab_a[k]     = '0;
			tab_b[k]     = '0;
			tab_c[k]     = '0;
			tab_count[k] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset limit, then under limit zero.
		queue_sig('0, '0, '0);
		queue_sig(32'h1, '0, '0);
		queue_sig('0, 32'h1, '0);
		queue_sig('0, '0, 32'h1);
		queue_sig(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		queue_sig(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		repeat (6) queue_sig('1, '1, '1);
		queue_sig(32'h1, '0, '0);
		queue_sig('0, '0, '0);
		wait_drained();
		set_limit('0);
		queue_sig(32'h1, '0, '0);
		queue_sig('0, 32'h1, '0);
		queue_sig(32'hDEAD_BEEF, '0, 32'hFFFF_FFFF);
		queue_sig(32'hDEAD_BEEF, '0, 32'hFFFF_FFFF);

		set_limit(16'd1);
		run_random(80);
		set_limit('0);
		run_random(60);
		set_limit('1);
		run_random(60);
		set_limit(LIMIT_W'($urandom_range(20, 2)));
		idle_pct = 0;
		run_random(90);
		idle_pct = 13;
		set_limit(LIMIT_W'($urandom_range(65535)));
		run_random(50);
		set_limit(16'd3);
		run_random(60);

		// With the top limit a purge clears the whole table.
		set_limit('1);
		while (occupied() > 0) begin
			need = ENTRIES - occupied() + 1;
			repeat (need) begin
				queue_sig(tag, $urandom, $urandom);
				tag++;
			end
			wait_drained();
		end
		set_limit(16'hFFFE);
		queue_sig(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		queue_sig(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
		wait_drained();
		repeat (LATENCY) @(negedge clk);

		$display("Results: %0d ignored, %0d matched (%0d flagged repeat), %0d inserted, %0d purges.",
			tally[ACT_IGNORED], tally[ACT_MATCHED], repeats_seen,
			tally[ACT_INSERTED], tally[ACT_PURGED]);
		$display("Limits 0, 1, 3, 65534, 65535 and random were used; a full purge emptied the table.");
		if (errors == 0 && expected_verdicts.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/rsig_pkg.sv
design/rsig_ifs.sv
design/repeat_signature_table_top.sv
design/rsig_checker.sv
test/repeat_signature_table_top_tb.sv
